### sv/rmj_pkg.sv
// ----------------------------------------------------------------------------
// rmj_pkg: shared definitions for the radar measurement Jacobian
// Default widths, configuration register size and reset value, and the
// sideband record that travels beside the datapath.
// ----------------------------------------------------------------------------
package rmj_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // minimum squared radius register
    localparam int               CFG_W             = 16;
    localparam logic [CFG_W-1:0] MIN_SQ_RADIUS_RST = 16'd7;

    // per-item control that rides alongside the arithmetic
    typedef struct packed {
        logic valid;
        logic degenerate;
        logic px_neg;
        logic py_neg;
        logic c_neg;
    } side_t;

endpackage

### sv/rmj_sqrt.sv
// ----------------------------------------------------------------------------
// rmj_sqrt: pipelined integer square root
// Restoring square root, one root bit per stage, MSB first. Gives
// floor(sqrt(in_rad)) after ROOT_W stages and carries a payload alongside.
// ----------------------------------------------------------------------------
module rmj_sqrt
    import rmj_pkg::*;
#(
    parameter int ROOT_W = DATA_WIDTH_DEF,
    parameter int PAY_W  = 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [2*ROOT_W-1:0]   in_rad,
    input  logic [PAY_W-1:0]      in_pay,
    output logic                  out_valid,
    output logic [ROOT_W-1:0]     out_root,
    output logic [PAY_W-1:0]      out_pay
);

    localparam int RAD_W = 2 * ROOT_W;

    logic [RAD_W-1:0]  rem_reg  [0:ROOT_W-2];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W-1];
    logic [PAY_W-1:0]  pay_reg  [0:ROOT_W-1];
    logic              vld_reg  [0:ROOT_W-1];

    genvar j;
    generate
        for (j = 0; j < ROOT_W; j++)
        begin : g_stage
            localparam int BIT_IDX = ROOT_W - 1 - j;

            logic [RAD_W-1:0]  rem_in;
            logic [ROOT_W-1:0] root_in;
            logic [PAY_W-1:0]  pay_in;
            logic              vld_in;
            logic [RAD_W:0]    trial;
            logic              take;

            if (j == 0)
            begin : g_src
                assign rem_in  = in_rad;
                assign root_in = '0;
                assign pay_in  = in_pay;
                assign vld_in  = in_valid;
            end
            else
            begin : g_src
                assign rem_in  = rem_reg[j-1];
                assign root_in = root_reg[j-1];
                assign pay_in  = pay_reg[j-1];
                assign vld_in  = vld_reg[j-1];
            end

            // (2*root + bit) * bit, with bit = 2^BIT_IDX
            assign trial = ({{(ROOT_W+1){1'b0}}, root_in} << (BIT_IDX + 1))
                         | ((RAD_W+1)'(1) << (2 * BIT_IDX));
            assign take  = {1'b0, rem_in} >= trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[j] <= 1'b0;
                else if (en)
                    vld_reg[j] <= vld_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    root_reg[j] <= take ? (root_in | (ROOT_W'(1) << BIT_IDX)) : root_in;
                    pay_reg[j]  <= pay_in;
                end
            end

            if (j < ROOT_W - 1)
            begin : g_rem
                always_ff @(posedge clk)
                begin
                    if (en)
                        rem_reg[j] <= take ? RAD_W'({1'b0, rem_in} - trial) : rem_in;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_pay   = pay_reg[ROOT_W-1];

endmodule

### sv/rmj_div.sv
// ----------------------------------------------------------------------------
// rmj_div: pipelined saturating unsigned divider
// First stage flags a quotient of 2^QW or more; then one restoring step per
// stage yields the low QW quotient bits.
// ----------------------------------------------------------------------------
module rmj_div
    import rmj_pkg::*;
#(
    parameter int NUM_W = 2 * DATA_WIDTH_DEF,
    parameter int DEN_W = DATA_WIDTH_DEF,
    parameter int QW    = DATA_WIDTH_DEF - 1
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QW-1:0]    quo,
    output logic             ovf
);

    localparam int RW = (NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW;

    logic [RW-1:0]    rem_reg [0:QW-1];
    logic [DEN_W-1:0] den_reg [0:QW-1];
    logic [QW-1:0]    quo_reg [0:QW];
    logic             ovf_reg [0:QW];

    logic [RW-1:0] num_ext;
    logic [RW-1:0] den_top;

    assign num_ext = RW'(num);
    assign den_top = RW'(den) << QW;

    // overflow check, capture operands
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num_ext;
            den_reg[0] <= den;
            quo_reg[0] <= '0;
            ovf_reg[0] <= num_ext >= den_top;
        end
    end

    genvar k;
    generate
        for (k = 1; k <= QW; k++)
        begin : g_step
            localparam int BIT_IDX = QW - k;

            logic [RW-1:0] trial;
            logic          take;

            assign trial = RW'(den_reg[k-1]) << BIT_IDX;
            assign take  = rem_reg[k-1] >= trial;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    quo_reg[k] <= take ? (quo_reg[k-1] | (QW'(1) << BIT_IDX))
                                       : quo_reg[k-1];
                    ovf_reg[k] <= ovf_reg[k-1];
                end
            end

            if (k < QW)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[k] <= take ? (rem_reg[k-1] - trial) : rem_reg[k-1];
                        den_reg[k] <= den_reg[k-1];
                    end
                end
            end
        end
    endgenerate

    assign quo = quo_reg[QW];
    assign ovf = ovf_reg[QW];

endmodule

### sv/radar_measurement_jacobian.sv
// Throughput: one transaction per cycle while in_ready is high; the square root and
// the six dividers are pipelines that resolve one result bit per stage.
// A two-entry output buffer keeps intake running while one result waits.
// Reset (rst_n low, asynchronous) clears all valid bits and sets
// min_square_radius to 7.
// ----------------------------------------------------------------------------
// radar_measurement_jacobian: radar range/bearing/range-rate Jacobian
// Squares and cross products, floor square root, then six saturating
// fixed point divisions; degenerate positions give zeros and a flag.
// ----------------------------------------------------------------------------
module radar_measurement_jacobian
    import rmj_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // input channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] pos_x,
    input  logic signed [DATA_WIDTH-1:0] pos_y,
    input  logic signed [DATA_WIDTH-1:0] vel_x,
    input  logic signed [DATA_WIDTH-1:0] vel_y,
    // result channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] range_d_px,
    output logic signed [DATA_WIDTH-1:0] range_d_py,
    output logic signed [DATA_WIDTH-1:0] bearing_d_px,
    output logic signed [DATA_WIDTH-1:0] bearing_d_py,
    output logic signed [DATA_WIDTH-1:0] rate_d_px,
    output logic signed [DATA_WIDTH-1:0] rate_d_py,
    output logic                         degenerate,
    // configuration channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_W-1:0]             min_square_radius
);

    localparam int W      = DATA_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int QW     = W - 1;
    localparam int SW     = 2 * W;
    localparam int SRW    = 3 * W;
    localparam int RNG_NW = W + F;
    localparam int BRG_NW = W + 2 * F;
    localparam int RAT_NW = SRW + F;
    localparam int THR_W  = (SW > CFG_W + F) ? SW : CFG_W + F;
    localparam int PAY_W  = 2 * W + 2 * SW + 4;

    typedef struct packed {
        logic [W-1:0] rx;
        logic [W-1:0] ry;
        logic [W-1:0] bx;
        logic [W-1:0] by;
        logic [W-1:0] tx;
        logic [W-1:0] ty;
        logic         deg;
    } res_t;

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        return v[W-1] ? (~v + W'(1)) : v;
    endfunction

    // clamp a quotient magnitude into the signed range and apply the sign
    function automatic logic [W-1:0] pack(input logic [QW-1:0] q, input logic ov,
                                          input logic neg);
        logic [W-1:0] m;
        m = ov ? (W'(1) << (W - 1)) : {1'b0, q};
        if (neg)
            return ~m + W'(1);
        else if (m[W-1])
            return {1'b0, {(W-1){1'b1}}};
        else
            return m;
    endfunction

    logic adv;
    logic skid_valid_reg;
    logic out_valid_reg;

    assign adv       = !skid_valid_reg;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    // configuration register
    logic [CFG_W-1:0] msr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            msr_reg <= MIN_SQ_RADIUS_RST;
        else if (cfg_valid)
            msr_reg <= min_square_radius;
    end

    // ---------------- stage A: input capture ----------------
    logic         a_valid_reg;
    logic [W-1:0] a_px_reg, a_py_reg, a_vx_reg, a_vy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (adv)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_px_reg <= pos_x;
            a_py_reg <= pos_y;
            a_vx_reg <= vel_x;
            a_vy_reg <= vel_y;
        end
    end

    // ---------------- stage B: magnitudes and products ----------------
    logic [W-1:0] b_pxm_next, b_pym_next, b_vxm_next, b_vym_next;

    assign b_pxm_next = mag_of(a_px_reg);
    assign b_pym_next = mag_of(a_py_reg);
    assign b_vxm_next = mag_of(a_vx_reg);
    assign b_vym_next = mag_of(a_vy_reg);

    logic          b_valid_reg;
    logic [W-1:0]  b_pxm_reg, b_pym_reg;
    logic          b_pxn_reg, b_pyn_reg, b_t1n_reg, b_t2n_reg;
    logic [SW-1:0] b_xx_reg, b_yy_reg, b_t1_reg, b_t2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (adv)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_pxm_reg <= b_pxm_next;
            b_pym_reg <= b_pym_next;
            b_pxn_reg <= a_px_reg[W-1];
            b_pyn_reg <= a_py_reg[W-1];
            b_t1n_reg <= a_vx_reg[W-1] ^ a_py_reg[W-1];
            b_t2n_reg <= a_vy_reg[W-1] ^ a_px_reg[W-1];
            b_xx_reg  <= b_pxm_next * b_pxm_next;
            b_yy_reg  <= b_pym_next * b_pym_next;
            b_t1_reg  <= b_vxm_next * b_pym_next;
            b_t2_reg  <= b_vym_next * b_pxm_next;
        end
    end

    // ---------------- stage C: s and cross-term sums ----------------
    logic          c_valid_reg;
    logic [W-1:0]  c_pxm_reg, c_pym_reg;
    logic          c_pxn_reg, c_pyn_reg, c_t1n_reg, c_t2n_reg;
    logic [SW-1:0] c_s_reg, c_sum_reg;
    logic [SW:0]   c_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (adv)
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_pxm_reg <= b_pxm_reg;
            c_pym_reg <= b_pym_reg;
            c_pxn_reg <= b_pxn_reg;
            c_pyn_reg <= b_pyn_reg;
            c_t1n_reg <= b_t1n_reg;
            c_t2n_reg <= b_t2n_reg;
            c_s_reg   <= b_xx_reg + b_yy_reg;
            c_sum_reg <= b_t1_reg + b_t2_reg;
            c_d_reg   <= {1'b0, b_t1_reg} - {1'b0, b_t2_reg};
        end
    end

    // ---------------- stage D: |c|, sign, degenerate test ----------------
    logic [SW-1:0] d_cm_next;
    logic          d_cneg_next;
    logic          d_deg_next;

    // c = vx*py - vy*px from the signed product magnitudes
    always_comb
    begin
        if (c_t1n_reg == c_t2n_reg)
        begin
            d_cm_next   = c_d_reg[SW] ? SW'(-c_d_reg) : c_d_reg[SW-1:0];
            d_cneg_next = c_t1n_reg ? (!c_d_reg[SW] && (c_d_reg != '0)) : c_d_reg[SW];
        end
        else
        begin
            d_cm_next   = c_sum_reg;
            d_cneg_next = c_t1n_reg && (c_sum_reg != '0);
        end
    end

    assign d_deg_next = (c_s_reg == '0)
                     || (THR_W'(c_s_reg) < (THR_W'(msr_reg) << F));

    logic          d_valid_reg;
    logic [W-1:0]  d_pxm_reg, d_pym_reg;
    logic          d_pxn_reg, d_pyn_reg, d_cneg_reg, d_deg_reg;
    logic [SW-1:0] d_s_reg, d_cm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else if (adv)
            d_valid_reg <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_pxm_reg  <= c_pxm_reg;
            d_pym_reg  <= c_pym_reg;
            d_pxn_reg  <= c_pxn_reg;
            d_pyn_reg  <= c_pyn_reg;
            d_s_reg    <= c_s_reg;
            d_cm_reg   <= d_cm_next;
            d_cneg_reg <= d_cneg_next;
            d_deg_reg  <= d_deg_next;
        end
    end

    // ---------------- square root pipeline ----------------
    logic [PAY_W-1:0] sq_pay_in, sq_pay_out;
    logic             sq_valid;
    logic [W-1:0]     sq_root;
    logic [W-1:0]     sq_pxm, sq_pym;
    logic [SW-1:0]    sq_s, sq_cm;
    logic             sq_pxn, sq_pyn, sq_cneg, sq_deg;

    assign sq_pay_in = {d_pxm_reg, d_pym_reg, d_s_reg, d_cm_reg,
                        d_pxn_reg, d_pyn_reg, d_cneg_reg, d_deg_reg};
    assign {sq_pxm, sq_pym, sq_s, sq_cm, sq_pxn, sq_pyn, sq_cneg, sq_deg} = sq_pay_out;

    rmj_sqrt #(
        .ROOT_W (W),
        .PAY_W  (PAY_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (d_valid_reg),
        .in_rad    (d_s_reg),
        .in_pay    (sq_pay_in),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_pay   (sq_pay_out)
    );

    // ---------------- stage M1: partial products ----------------
    side_t         m1_side_reg;
    logic [W-1:0]  m1_pxm_reg, m1_pym_reg, m1_r_reg;
    logic [SW-1:0] m1_s_reg;
    logic [SW-1:0] m1_sr_hi_reg, m1_sr_lo_reg;
    logic [SW-1:0] m1_yc_hi_reg, m1_yc_lo_reg, m1_xc_hi_reg, m1_xc_lo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m1_side_reg <= '0;
        else if (adv)
        begin
            m1_side_reg.valid      <= sq_valid;
            m1_side_reg.degenerate <= sq_deg;
            m1_side_reg.px_neg     <= sq_pxn;
            m1_side_reg.py_neg     <= sq_pyn;
            m1_side_reg.c_neg      <= sq_cneg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_pxm_reg   <= sq_pxm;
            m1_pym_reg   <= sq_pym;
            m1_r_reg     <= sq_root;
            m1_s_reg     <= sq_s;
            m1_sr_hi_reg <= sq_s[SW-1:W] * sq_root;
            m1_sr_lo_reg <= sq_s[W-1:0] * sq_root;
            m1_yc_hi_reg <= sq_pym * sq_cm[SW-1:W];
            m1_yc_lo_reg <= sq_pym * sq_cm[W-1:0];
            m1_xc_hi_reg <= sq_pxm * sq_cm[SW-1:W];
            m1_xc_lo_reg <= sq_pxm * sq_cm[W-1:0];
        end
    end

    // ---------------- stage M2: product sums, numerators ----------------
    side_t              m2_side_reg;
    logic [RNG_NW-1:0]  m2_rx_num_reg, m2_ry_num_reg;
    logic [BRG_NW-1:0]  m2_bx_num_reg, m2_by_num_reg;
    logic [RAT_NW-1:0]  m2_tx_num_reg, m2_ty_num_reg;
    logic [W-1:0]       m2_r_reg;
    logic [SW-1:0]      m2_s_reg;
    logic [SRW-1:0]     m2_sr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m2_side_reg <= '0;
        else if (adv)
            m2_side_reg <= m1_side_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m2_rx_num_reg <= {m1_pxm_reg, {F{1'b0}}};
            m2_ry_num_reg <= {m1_pym_reg, {F{1'b0}}};
            m2_bx_num_reg <= {m1_pym_reg, {(2*F){1'b0}}};
            m2_by_num_reg <= {m1_pxm_reg, {(2*F){1'b0}}};
            m2_tx_num_reg <= {(SRW'(m1_yc_hi_reg) << W) + SRW'(m1_yc_lo_reg), {F{1'b0}}};
            m2_ty_num_reg <= {(SRW'(m1_xc_hi_reg) << W) + SRW'(m1_xc_lo_reg), {F{1'b0}}};
            m2_r_reg      <= m1_r_reg;
            m2_s_reg      <= m1_s_reg;
            m2_sr_reg     <= (SRW'(m1_sr_hi_reg) << W) + SRW'(m1_sr_lo_reg);
        end
    end

    // ---------------- divider pipelines ----------------
    logic [QW-1:0] rx_quo, ry_quo, bx_quo, by_quo, tx_quo, ty_quo;
    logic          rx_ovf, ry_ovf, bx_ovf, by_ovf, tx_ovf, ty_ovf;

    rmj_div #(.NUM_W(RNG_NW), .DEN_W(W), .QW(QW)) u_div_rx (
        .clk(clk), .en(adv), .num(m2_rx_num_reg), .den(m2_r_reg),
        .quo(rx_quo), .ovf(rx_ovf)
    );

    rmj_div #(.NUM_W(RNG_NW), .DEN_W(W), .QW(QW)) u_div_ry (
        .clk(clk), .en(adv), .num(m2_ry_num_reg), .den(m2_r_reg),
        .quo(ry_quo), .ovf(ry_ovf)
    );

    rmj_div #(.NUM_W(BRG_NW), .DEN_W(SW), .QW(QW)) u_div_bx (
        .clk(clk), .en(adv), .num(m2_bx_num_reg), .den(m2_s_reg),
        .quo(bx_quo), .ovf(bx_ovf)
    );

    rmj_div #(.NUM_W(BRG_NW), .DEN_W(SW), .QW(QW)) u_div_by (
        .clk(clk), .en(adv), .num(m2_by_num_reg), .den(m2_s_reg),
        .quo(by_quo), .ovf(by_ovf)
    );

    rmj_div #(.NUM_W(RAT_NW), .DEN_W(SRW), .QW(QW)) u_div_tx (
        .clk(clk), .en(adv), .num(m2_tx_num_reg), .den(m2_sr_reg),
        .quo(tx_quo), .ovf(tx_ovf)
    );

    rmj_div #(.NUM_W(RAT_NW), .DEN_W(SRW), .QW(QW)) u_div_ty (
        .clk(clk), .en(adv), .num(m2_ty_num_reg), .den(m2_sr_reg),
        .quo(ty_quo), .ovf(ty_ovf)
    );

    // sideband delay matching the divider latency
    side_t side_line_reg [0:W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < W; k++)
                side_line_reg[k] <= '0;
        end
        else if (adv)
        begin
            side_line_reg[0] <= m2_side_reg;
            for (int k = 1; k < W; k++)
                side_line_reg[k] <= side_line_reg[k-1];
        end
    end

    // ---------------- result formatting ----------------
    side_t side_out;
    res_t  push_res;
    logic  push_valid;

    assign side_out   = side_line_reg[W-1];
    assign push_valid = side_out.valid && adv;

    always_comb
    begin
        if (side_out.degenerate)
        begin
            push_res     = '0;
            push_res.deg = 1'b1;
        end
        else
        begin
            push_res.rx  = pack(rx_quo, rx_ovf, side_out.px_neg);
            push_res.ry  = pack(ry_quo, ry_ovf, side_out.py_neg);
            push_res.bx  = pack(bx_quo, bx_ovf, !side_out.py_neg);
            push_res.by  = pack(by_quo, by_ovf, side_out.px_neg);
            push_res.tx  = pack(tx_quo, tx_ovf, side_out.py_neg != side_out.c_neg);
            push_res.ty  = pack(ty_quo, ty_ovf, side_out.px_neg == side_out.c_neg);
            push_res.deg = 1'b0;
        end
    end

    // ---------------- output register with skid entry ----------------
    res_t out_res_reg, skid_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= push_valid;
        end
        else if (push_valid)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
            out_res_reg <= skid_valid_reg ? skid_res_reg : push_res;
        else if (push_valid)
            skid_res_reg <= push_res;
    end

    assign out_valid    = out_valid_reg;
    assign range_d_px   = out_res_reg.rx;
    assign range_d_py   = out_res_reg.ry;
    assign bearing_d_px = out_res_reg.bx;
    assign bearing_d_py = out_res_reg.by;
    assign rate_d_px    = out_res_reg.tx;
    assign rate_d_py    = out_res_reg.ty;
    assign degenerate   = out_res_reg.deg;

endmodule

### sv/rmj_checker.sv
// ----------------------------------------------------------------------------
// rmj_checker: port-level assertions for radar_measurement_jacobian
// Watches the handshakes and the result fields; bound to the top level.
// ----------------------------------------------------------------------------
module rmj_checker
    import rmj_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [DATA_WIDTH-1:0] range_d_px,
    input logic [DATA_WIDTH-1:0] range_d_py,
    input logic [DATA_WIDTH-1:0] bearing_d_px,
    input logic [DATA_WIDTH-1:0] bearing_d_py,
    input logic [DATA_WIDTH-1:0] rate_d_px,
    input logic [DATA_WIDTH-1:0] rate_d_py,
    input logic                  degenerate
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(range_d_px)
            && $stable(rate_d_py) && $stable(degenerate))
        else $error("result changed while stalled");

    // intake stops only while a result is waiting
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("intake stalled with no pending result");

    // degenerate state zeroes every entry
    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> range_d_px == '0 && range_d_py == '0
            && bearing_d_px == '0 && bearing_d_py == '0
            && rate_d_px == '0 && rate_d_py == '0)
        else $error("degenerate result with nonzero entries");

    // px/r and px/s share the sign of px
    a_px_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_d_px[DATA_WIDTH-1]
            |-> bearing_d_py[DATA_WIDTH-1] || bearing_d_py == '0)
        else $error("px/r and px/s disagree in sign");

    // py/r and -py/s have opposite signs
    a_py_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_d_py[DATA_WIDTH-1] |-> !bearing_d_px[DATA_WIDTH-1])
        else $error("py/r and -py/s share a sign");

endmodule

bind radar_measurement_jacobian rmj_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_rmj_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .range_d_px   (range_d_px),
    .range_d_py   (range_d_py),
    .bearing_d_px (bearing_d_px),
    .bearing_d_py (bearing_d_py),
    .rate_d_px    (rate_d_px),
    .rate_d_py    (rate_d_py),
    .degenerate   (degenerate)
);
